### sv/rc4drc_pkg.sv
// Shared types and constants for the RC4 decrypt / rotating checksum block.
// Holds the control word layout, step codes and the microcode ROM contents.
// No dependencies.
`default_nettype none

package rc4drc_pkg;

    // Key chaining seed
    localparam logic [15:0] KEY_SEED = 16'h3fa2;

    // Sequencer step codes
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] ST_INIT = 4'd1;
    localparam logic [STEP_W-1:0] ST_KA   = 4'd2;
    localparam logic [STEP_W-1:0] ST_KB   = 4'd3;
    localparam logic [STEP_W-1:0] ST_KC   = 4'd4;
    localparam logic [STEP_W-1:0] ST_KD   = 4'd5;
    localparam logic [STEP_W-1:0] ST_KEND = 4'd6;
    localparam logic [STEP_W-1:0] ST_P1   = 4'd7;
    localparam logic [STEP_W-1:0] ST_P2   = 4'd8;
    localparam logic [STEP_W-1:0] ST_P3   = 4'd9;
    localparam logic [STEP_W-1:0] ST_P4   = 4'd10;
    localparam logic [STEP_W-1:0] ST_P5   = 4'd11;
    localparam logic [STEP_W-1:0] ST_P6   = 4'd12;

    // Memory read address select
    localparam logic [1:0] RA_CNT   = 2'd0;  // loop counter
    localparam logic [1:0] RA_JSUM  = 2'd1;  // j + S[..] (+ key byte)
    localparam logic [1:0] RA_INEXT = 2'd2;  // i + 1
    localparam logic [1:0] RA_SISJ  = 2'd3;  // S[i] + S[j]

    // Memory write select (address / data)
    localparam logic [2:0] WR_NONE    = 3'd0;
    localparam logic [2:0] WR_CNT_CNT = 3'd1;  // S[cnt] = cnt
    localparam logic [2:0] WR_CNT_RD  = 3'd2;  // S[cnt] = read data
    localparam logic [2:0] WR_J_SI    = 3'd3;  // S[j] = saved S[i]
    localparam logic [2:0] WR_I_RD    = 3'd4;  // S[i] = read data

    // Jump conditions
    localparam logic [2:0] CJ_NEXT     = 3'd0;
    localparam logic [2:0] CJ_GOTO     = 3'd1;
    localparam logic [2:0] CJ_WAIT_IN  = 3'd2;  // hold until a word is taken
    localparam logic [2:0] CJ_LOOP     = 3'd3;  // repeat until counter wraps
    localparam logic [2:0] CJ_WAIT_OUT = 3'd4;  // hold while result reg is full

    // One microcode word
    typedef struct packed {
        logic              rd_en;
        logic [1:0]        rd_sel;
        logic [2:0]        wr_sel;
        logic              ld_si;
        logic              ld_j;
        logic              ld_i;
        logic              ld_sj;
        logic              use_key;
        logic              clr_ij;
        logic              set_keyed;
        logic              finish;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // Status fed back to the sequencer
    typedef struct packed {
        logic in_accept;
        logic keyed;
        logic cnt_last;
        logic out_blocked;
    } seq_stat_t;

    // Microcode ROM
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '0;
        w.cond = CJ_NEXT;
        w.target = ST_IDLE;
        case (step)
            ST_IDLE:
            begin
                w.cond = CJ_WAIT_IN;
                w.target = ST_P1;
            end
            ST_INIT:
            begin
                w.wr_sel = WR_CNT_CNT;
                w.clr_ij = 1'b1;
                w.cond = CJ_LOOP;
                w.target = ST_INIT;
            end
            ST_KA:
            begin
                w.rd_en = 1'b1;
                w.rd_sel = RA_CNT;
            end
            ST_KB:
            begin
                w.rd_en = 1'b1;
                w.rd_sel = RA_JSUM;
                w.ld_si = 1'b1;
                w.ld_j = 1'b1;
                w.use_key = 1'b1;
            end
            ST_KC:
            begin
                w.wr_sel = WR_CNT_RD;
            end
            ST_KD:
            begin
                w.wr_sel = WR_J_SI;
                w.cond = CJ_LOOP;
                w.target = ST_KA;
            end
            ST_KEND:
            begin
                w.clr_ij = 1'b1;
                w.set_keyed = 1'b1;
            end
            ST_P1:
            begin
                w.rd_en = 1'b1;
                w.rd_sel = RA_INEXT;
                w.ld_i = 1'b1;
            end
            ST_P2:
            begin
                w.rd_en = 1'b1;
                w.rd_sel = RA_JSUM;
                w.ld_si = 1'b1;
                w.ld_j = 1'b1;
            end
            ST_P3:
            begin
                w.ld_sj = 1'b1;
                w.wr_sel = WR_I_RD;
            end
            ST_P4:
            begin
                w.wr_sel = WR_J_SI;
            end
            ST_P5:
            begin
                w.rd_en = 1'b1;
                w.rd_sel = RA_SISJ;
            end
            ST_P6:
            begin
                w.finish = 1'b1;
                w.cond = CJ_WAIT_OUT;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.cond = CJ_GOTO;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### sv/rc4drc_seq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on rc4drc_pkg.
`default_nettype none

module rc4drc_seq (
    input  wire                            clk,
    input  wire                            rst_n,
    input  rc4drc_pkg::seq_stat_t          stat,
    output rc4drc_pkg::ucode_t             ctrl,
    output logic [rc4drc_pkg::STEP_W-1:0]  step
);
    import rc4drc_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    // Control word for the current step
    assign ctrl = ucode_rom(step_reg);
    assign step = step_reg;

    // Next step
    always_comb
    begin
        case (ctrl.cond)
            CJ_NEXT:     step_next = step_reg + 1'b1;
            CJ_GOTO:     step_next = ctrl.target;
            CJ_WAIT_IN:
            begin
                if (!stat.in_accept)
                    step_next = step_reg;
                else if (stat.keyed)
                    step_next = ctrl.target;
                else
                    step_next = step_reg + 1'b1;
            end
            CJ_LOOP:     step_next = stat.cnt_last ? step_reg + 1'b1 : ctrl.target;
            CJ_WAIT_OUT: step_next = stat.out_blocked ? step_reg : ctrl.target;
            default:     step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_IDLE;
        else
            step_reg <= step_next;
    end

    // Checks
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= ST_P6) else $error("step out of program");
    a_wait_out: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_P6 && stat.out_blocked) |=> step_reg == ST_P6)
        else $error("left final step while result reg full");
    a_unkeyed: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_IDLE && stat.in_accept && !stat.keyed) |=> step_reg == ST_INIT)
        else $error("unkeyed word skipped key schedule");

endmodule

`default_nettype wire

### sv/rc4_decrypt_rotate_checksum.sv
// Top level: RC4 stream decryptor with rotating 16-bit checksum check.
// Depends on rc4drc_pkg and rc4drc_seq.
//
// Usage:
//   Input stream (s_*): one cipher byte per word in s_tdata, s_tlast marks
//   the last byte of a payload. Output stream (m_*): one decrypted byte per
//   input word, m_tlast copies the input flag, m_tuser is the checksum match
//   flag, valid only on the last word (0 elsewhere).
//   Config channel (cfg_*): index 0 writes the 48-bit station address,
//   index 1 the 16-bit expected check; other indexes are dropped. cfg_ready
//   is always high; write only while the block is idle.
// Sequence:
//   A keyed byte is returned after six microcode steps over one sbox
//   memory, following the idle step that takes it; no new byte is taken
//   until the block is back in the idle step. The first byte after reset or
//   after a last byte first runs the key schedule: the fill step once per
//   sbox entry, then steps KA to KD per entry, then the end step KEND.
// Reset clears the sequencer, indexes, checksum and output valid; the sbox is
// rebuilt by the key schedule. If the receiver stalls, the finished result
// waits in the output register and the block holds its last step until the
// register frees; a new input word is taken while that result waits.
`default_nettype none

module rc4_decrypt_rotate_checksum (
    input  wire         clk,
    input  wire         rst_n,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] cipher_byte
    input  wire         s_tlast,   // is_last
    // output stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [7:0] plain_byte
    output logic        m_tlast,   // last_out
    output logic        m_tuser,   // [0] check_ok
    // config write channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [47:0] cfg_data
);
    import rc4drc_pkg::*;

    localparam logic [1:0] REG_STATION = 2'd0;
    localparam logic [1:0] REG_CHECK   = 2'd1;

    ucode_t            ctrl;
    seq_stat_t         stat;
    logic [STEP_W-1:0] step;

    // Config registers
    logic [47:0] station_reg;
    logic [15:0] check_reg;

    // Datapath registers
    logic [7:0]  cnt_reg;
    logic [7:0]  i_reg;
    logic [7:0]  j_reg;
    logic [7:0]  si_reg;
    logic [7:0]  sj_reg;
    logic        keyed_reg;
    logic [15:0] sum_reg;
    logic [7:0]  held_reg;
    logic        parity_reg;
    logic [7:0]  cbyte_reg;
    logic        last_reg;

    // Output register
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [7:0]  m_data_reg;
    logic        m_last_reg;
    logic        m_ok_reg;

    // Sbox memory
    logic [7:0]  sbox_mem [256];
    logic [7:0]  rdata_reg;
    logic [7:0]  raddr;
    logic [7:0]  waddr;
    logic [7:0]  wdata;
    logic        we;

    logic        in_accept;
    logic        out_blocked;
    logic        fin;
    logic [15:0] c0, c1, c2, c3;
    logic [63:0] key_bytes;
    logic [7:0]  key_byte;
    logic [7:0]  j_sum;
    logic [7:0]  plain;
    logic [15:0] s_add;
    logic [15:0] sum_new;

    assign cfg_ready   = 1'b1;
    assign s_tready    = (step == ST_IDLE);
    assign in_accept   = s_tvalid && s_tready;
    assign out_blocked = m_tvalid_reg && !m_tready;
    assign fin         = ctrl.finish && !out_blocked;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_ok_reg;

    // Sequencer
    assign stat.in_accept   = in_accept;
    assign stat.keyed       = keyed_reg;
    assign stat.cnt_last    = (cnt_reg == 8'hff);
    assign stat.out_blocked = out_blocked;

    rc4drc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl),
        .step  (step)
    );

    // Key derivation: chained XOR of address / check words
    assign c0 = station_reg[15:0] ^ KEY_SEED;
    assign c1 = check_reg ^ c0;
    assign c2 = station_reg[47:32] ^ c1;
    assign c3 = station_reg[31:16] ^ c2;
    assign key_bytes = {c3, c2, c1, c0};
    assign key_byte  = key_bytes[{cnt_reg[2:0], 3'b000} +: 8];

    // j update path
    assign j_sum = j_reg + rdata_reg + (ctrl.use_key ? key_byte : 8'h00);

    // Read address
    always_comb
    begin
        case (ctrl.rd_sel)
            RA_CNT:   raddr = cnt_reg;
            RA_JSUM:  raddr = j_sum;
            RA_INEXT: raddr = i_reg + 8'd1;
            RA_SISJ:  raddr = si_reg + sj_reg;
            default:  raddr = cnt_reg;
        endcase
    end

    // Write address / data
    always_comb
    begin
        we    = 1'b1;
        waddr = cnt_reg;
        wdata = cnt_reg;
        case (ctrl.wr_sel)
            WR_CNT_CNT:
            begin
                waddr = cnt_reg;
                wdata = cnt_reg;
            end
            WR_CNT_RD:
            begin
                waddr = cnt_reg;
                wdata = rdata_reg;
            end
            WR_J_SI:
            begin
                waddr = j_reg;
                wdata = si_reg;
            end
            WR_I_RD:
            begin
                waddr = i_reg;
                wdata = rdata_reg;
            end
            default:  we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            sbox_mem[waddr] <= wdata;
        if (ctrl.rd_en)
            rdata_reg <= sbox_mem[raddr];
    end

    // Decrypt and checksum
    assign plain   = cbyte_reg ^ rdata_reg;
    assign s_add   = sum_reg + {plain, held_reg};
    assign sum_new = parity_reg ? {s_add[14:0], s_add[15]} : sum_reg;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= '0;
            check_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_STATION)
                station_reg <= cfg_data;
            else if (cfg_index == REG_CHECK)
                check_reg <= cfg_data[15:0];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            keyed_reg  <= 1'b0;
            sum_reg    <= '0;
            held_reg   <= '0;
            parity_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.cond == CJ_LOOP)
                cnt_reg <= cnt_reg + 8'd1;
            if (ctrl.ld_i)
                i_reg <= i_reg + 8'd1;
            if (ctrl.ld_j)
                j_reg <= j_sum;
            if (ctrl.clr_ij)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            if (ctrl.set_keyed)
                keyed_reg <= 1'b1;
            if (fin)
            begin
                if (last_reg)
                begin
                    keyed_reg  <= 1'b0;
                    i_reg      <= '0;
                    j_reg      <= '0;
                    sum_reg    <= '0;
                    held_reg   <= '0;
                    parity_reg <= 1'b0;
                end
                else
                begin
                    sum_reg    <= sum_new;
                    parity_reg <= !parity_reg;
                    if (!parity_reg)
                        held_reg <= plain;
                end
            end
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.ld_si)
            si_reg <= rdata_reg;
        if (ctrl.ld_sj)
            sj_reg <= rdata_reg;
        if (in_accept)
        begin
            cbyte_reg <= s_tdata;
            last_reg  <= s_tlast;
        end
    end

    // Output register
    always_comb
    begin
        if (fin)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            m_data_reg <= plain;
            m_last_reg <= last_reg;
            m_ok_reg   <= last_reg && (sum_new == check_reg);
        end
    end

    // Checks
    a_ok_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast) else $error("check flag on non-last word");
    a_rekey_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && last_reg) |=> !keyed_reg) else $error("key kept after last word");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step != ST_IDLE) |-> !s_tready) else $error("input taken while busy");

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking bench for rc4_decrypt_rotate_checksum: RC4 keystream plus checksum tracker.
// Drives cipher bytes and register writes, predicts each plain word and checks it in order.
// Depends on the block's RTL only.
`default_nettype none

typedef enum bit [1:0] {
    REG_STATION = 2'd0,
    REG_CHECK   = 2'd1,
    REG_SPARE_A = 2'd2,
    REG_SPARE_B = 2'd3
} reg_index_t;

typedef struct packed {
    bit [7:0] plain;
    bit       last;
    bit       ok;
} plain_rec_t;

typedef bit [7:0] byte_q_t [$];

// Tracks the cipher state and holds the plain words still due from the block
class plaintext_tracker;
    localparam bit [15:0] CHAIN_SEED = 16'h3fa2;

    bit [47:0]  station;
    bit [15:0]  want_sum;
    bit [7:0]   sbox [256];
    bit [7:0]   idx_i;
    bit [7:0]   idx_j;
    bit         keyed;
    bit [15:0]  sum;
    bit [7:0]   low_byte;
    bit         odd;
    plain_rec_t plain_due [$];
    int         errors;

    function void set_reg(reg_index_t idx, bit [47:0] value);
        case (idx)
            REG_STATION: station = value;
            REG_CHECK:   want_sum = value[15:0];
            default:     ;
        endcase
    endfunction

    // add the word, then rotate left by one
    function bit [15:0] fold(bit [15:0] s, bit [15:0] w);
        bit [15:0] t;
        t = s + w;
        return {t[14:0], t[15]};
    endfunction

    // key derivation and schedule from the current register values
    function void build_sbox();
        bit [15:0] words [4];
        bit [15:0] chain;
        bit [7:0]  key [8];
        bit [7:0]  j;
        bit [7:0]  t;
        words[0] = station[15:0];
        words[1] = want_sum;
        words[2] = station[47:32];
        words[3] = station[31:16];
        chain = CHAIN_SEED;
        j = 8'h00;
        for (int n = 0; n < 4; n++)
        begin
            chain = chain ^ words[n];
            key[2*n]   = chain[7:0];
            key[2*n+1] = chain[15:8];
        end
        for (int n = 0; n < 256; n++)
            sbox[n] = 8'(n);
        for (int n = 0; n < 256; n++)
        begin
            j = j + sbox[n] + key[n % 8];
            t = sbox[n];
            sbox[n] = sbox[j];
            sbox[j] = t;
        end
        idx_i = 8'h00;
        idx_j = 8'h00;
    endfunction

    function bit [7:0] keystream_byte();
        bit [7:0] t;
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + sbox[idx_i];
        t = sbox[idx_i];
        sbox[idx_i] = sbox[idx_j];
        sbox[idx_j] = t;
        t = sbox[idx_i] + sbox[idx_j];
        return sbox[t];
    endfunction

    // keystream of a payload not yet started; the real state rekeys anyway
    function byte_q_t fresh_keystream(int n);
        byte_q_t ks;
        build_sbox();
        repeat (n)
            ks.push_back(keystream_byte());
        idx_i = 8'h00;
        idx_j = 8'h00;
        return ks;
    endfunction

    function void take_cipher(bit [7:0] c, bit last);
        plain_rec_t r;
        if (!keyed)
        begin
            build_sbox();
            keyed = 1'b1;
        end
        r.plain = c ^ keystream_byte();
        r.last  = last;
        r.ok    = 1'b0;
        // pair bytes into little-endian words
        if (!odd)
        begin
            low_byte = r.plain;
            odd = 1'b1;
        end
        else
        begin
            sum = fold(sum, {r.plain, low_byte});
            odd = 1'b0;
        end
        // end of payload: compare, then back to rekey state
        if (last)
        begin
            r.ok = (sum == want_sum);
            keyed = 1'b0;
            idx_i = 8'h00;
            idx_j = 8'h00;
            sum = 16'h0000;
            low_byte = 8'h00;
            odd = 1'b0;
        end
        plain_due.push_back(r);
    endfunction

    function void match_plain(bit [7:0] d, bit l, bit ok);
        plain_rec_t e;
        if (plain_due.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected word, expected none, actual plain %02h last %0b ok %0b",
                     $time, d, l, ok);
            return;
        end
        e = plain_due.pop_front();
        if (d != e.plain)
        begin
            errors++;
            $display("%0t: plain_byte expected %02h actual %02h", $time, e.plain, d);
        end
        if (l != e.last)
        begin
            errors++;
            $display("%0t: last_out expected %0b actual %0b", $time, e.last, l);
        end
        if (ok != e.ok)
        begin
            errors++;
            $display("%0t: check_ok expected %0b actual %0b", $time, e.ok, ok);
        end
    endfunction
endclass

module testbench;
    localparam int QUIET_LIMIT = 8000;
    localparam int HOLD_CYCLES = 2000;
    localparam int ITEM_TARGET = 1450;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] cipher_byte
    logic        s_tlast = 1'b0;    // is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] plain_byte
    logic        m_tlast;           // last_out
    logic        m_tuser;           // [0] check_ok
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [47:0] cfg_data = 48'h0;

    plaintext_tracker board;
    int items_sent = 0;
    int results_seen = 0;
    int quiet = 0;
    int hold_left = 0;
    int holds_done = 0;

    rc4_decrypt_rotate_checksum dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // random gaps, none inside the burst window
    function automatic bit take_break(int count);
        if (count >= 600 && count < 800)
            return 1'b0;
        return $urandom_range(99) < 37;
    endfunction

    function automatic int payload_len();
        if ($urandom_range(19) == 0)
            return $urandom_range(300, 120);
        return $urandom_range(12, 1);
    endfunction

    // all tasks start and end at a falling edge
    task automatic send_word(input bit [7:0] b, input bit last);
        while (take_break(items_sent))
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        board.take_cipher(b, last);
        items_sent++;
        @(negedge clk);
    endtask

    // stop sending and let every due word come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.plain_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_register(input reg_index_t idx, input bit [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic pick_config();
        reg_index_t idx;
        bit [63:0]  raw;
        bit [47:0]  value;
        idx = ($urandom_range(9) < 8) ? reg_index_t'($urandom_range(1))
                                      : reg_index_t'($urandom_range(3, 2));
        raw = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       value = '0;
            1:       value = '1;
            default: value = raw[47:0];
        endcase
        set_register(idx, value);
    endtask

    // payload whose checksum matches: set the check first, since it feeds the key
    task automatic send_matched(input int len);
        byte_q_t   plain;
        byte_q_t   ks;
        bit [15:0] sum;
        sum = 16'h0000;
        for (int k = 0; k < len; k++)
            plain.push_back(8'($urandom_range(255)));
        for (int k = 0; k + 1 < len; k += 2)
            sum = board.fold(sum, {plain[k+1], plain[k]});
        drain();
        set_register(REG_CHECK, {32'h0, sum});
        ks = board.fresh_keystream(len);
        for (int k = 0; k < len; k++)
            send_word(plain[k] ^ ks[k], k == len - 1);
    endtask

    // random payload, now and then cut by a register write
    task automatic send_payload(input int len);
        for (int k = 0; k < len; k++)
        begin
            if (k > 0 && $urandom_range(24) == 0)
            begin
                drain();
                pick_config();
            end
            send_word(8'($urandom_range(255)), k == len - 1);
        end
    endtask

    task automatic run_directed();
        // reset values, single odd byte
        send_word(8'h00, 1'b1);
        drain();
        // register extremes, even payload
        set_register(REG_STATION, '1);
        set_register(REG_CHECK, 48'h00_0000_ffff);
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h01, 1'b1);
        drain();
        // indexes past the register list are dropped
        set_register(REG_SPARE_A, 48'h5a5a_a5a5_0f0f);
        set_register(REG_SPARE_B, '1);
        send_word(8'hff, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h7f, 1'b1);
        drain();
        set_register(REG_STATION, 48'h0123_4567_89ab);
        send_matched(6);
        send_matched(1);
        // writes mid-payload: key keeps old values, compare takes the new check
        send_word(8'h3c, 1'b0);
        send_word(8'hc3, 1'b0);
        send_word(8'h11, 1'b0);
        drain();
        set_register(REG_CHECK, 48'h0);
        set_register(REG_STATION, 48'h0);
        send_word(8'he7, 1'b0);
        send_word(8'h18, 1'b1);
    endtask

    task automatic run_random();
        int pick;
        int len;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(99);
            // keep the total close to the target
            len = payload_len();
            if (len > ITEM_TARGET - items_sent)
                len = ITEM_TARGET - items_sent;
            if (pick < 10)
            begin
                drain();
                pick_config();
            end
            else if (pick < 30)
                send_matched(len);
            else
                send_payload(len);
        end
    endtask

    // main sequence
    initial
    begin
        board = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        run_random();
        s_tvalid <= 1'b0;
        while (board.plain_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls plus two long hold-offs
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if ((holds_done == 0 && results_seen >= 150) ||
                     (holds_done == 1 && results_seen >= 1000))
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !take_break(results_seen);
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                board.match_plain(m_tdata, m_tlast, m_tuser);
                results_seen++;
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end
endmodule

`default_nettype wire

### sim.f
sv/rc4drc_pkg.sv
sv/rc4drc_seq.sv
sv/rc4_decrypt_rotate_checksum.sv
sim/testbench.sv
